FILE: design/icl_pkg.sv
// icl_pkg: recognizer phase types, literal form codes and character-class
// and next-phase functions for the integer literal classifier.
// No dependencies.
package icl_pkg;

    localparam int CharWidth = 8;
    localparam int FormWidth = 2;
    localparam int OutDataWidth = 8;

    typedef logic [CharWidth-1:0] char_t;

    typedef enum logic [3:0] {
        PP_LEAD      = 4'd0,
        PP_SIGNED    = 4'd1,
        PP_ZERO      = 4'd2,
        PP_HEX       = 4'd3,
        PP_OCT       = 4'd4,
        PP_DEC       = 4'd5,
        PP_SUF       = 4'd6,
        PP_TRAIL_HEX = 4'd7,
        PP_TRAIL_OCT = 4'd8,
        PP_TRAIL_DEC = 4'd9,
        PP_FAIL_HEX  = 4'd10,
        PP_FAIL_OCT  = 4'd11,
        PP_FAIL_DEC  = 4'd12
    } prefix_phase_t;

    typedef enum logic [2:0] {
        SP_LEAD  = 3'd0,
        SP_DIG   = 3'd1,
        SP_E     = 3'd2,
        SP_EXPD  = 3'd3,
        SP_TRAIL = 3'd4,
        SP_FAIL  = 3'd5
    } sci_phase_t;

    typedef enum logic [FormWidth-1:0] {
        FORM_SCI = 2'd0,
        FORM_OCT = 2'd1,
        FORM_HEX = 2'd2,
        FORM_DEC = 2'd3
    } literal_form_t;

    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_POINT = 8'h2E;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_SEVEN = 8'h37;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_UP_A  = 8'h41;
    localparam char_t CH_UP_E  = 8'h45;
    localparam char_t CH_UP_F  = 8'h46;
    localparam char_t CH_UP_L  = 8'h4C;
    localparam char_t CH_UP_U  = 8'h55;
    localparam char_t CH_LO_A  = 8'h61;
    localparam char_t CH_LO_E  = 8'h65;
    localparam char_t CH_LO_F  = 8'h66;
    localparam char_t CH_LO_L  = 8'h6C;
    localparam char_t CH_LO_U  = 8'h75;
    localparam char_t CH_LO_X  = 8'h78;
    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;

    function automatic logic is_ws(input char_t c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    function automatic logic is_dig(input char_t c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_oct(input char_t c);
        return c inside {[CH_ZERO:CH_SEVEN]};
    endfunction

    function automatic logic is_hex(input char_t c);
        return is_dig(c) || (c inside {[CH_LO_A:CH_LO_F]}) || (c inside {[CH_UP_A:CH_UP_F]});
    endfunction

    function automatic logic is_sfx(input char_t c);
        return c inside {CH_LO_U, CH_UP_U, CH_LO_L, CH_UP_L};
    endfunction

    function automatic logic is_e(input char_t c);
        return (c == CH_LO_E) || (c == CH_UP_E);
    endfunction

    function automatic logic is_sign(input char_t c);
        return (c == CH_PLUS) || (c == CH_MINUS);
    endfunction

    // decimal digit loop entry
    function automatic prefix_phase_t dec_step(input char_t c);
        if (is_dig(c)) return PP_DEC;
        if (is_sfx(c)) return PP_SUF;
        if (is_ws(c)) return PP_TRAIL_DEC;
        return PP_FAIL_DEC;
    endfunction

    function automatic prefix_phase_t prefix_next(input prefix_phase_t p, input char_t c);
        prefix_phase_t n;
        n = PP_FAIL_DEC;
        case (p)
            PP_LEAD: begin
                if (is_ws(c)) n = PP_LEAD;
                else if (is_sign(c)) n = PP_SIGNED;
                else if (c == CH_ZERO) n = PP_ZERO;
                else n = dec_step(c);
            end
            PP_SIGNED: begin
                if (c == CH_ZERO) n = PP_ZERO;
                else n = dec_step(c);
            end
            PP_ZERO: begin
                if (c == CH_LO_X) n = PP_HEX;
                else if (is_oct(c)) n = PP_OCT;
                else if (is_dig(c)) n = PP_FAIL_OCT;
                else n = dec_step(c);
            end
            PP_HEX: begin
                if (is_hex(c)) n = PP_HEX;
                else n = is_ws(c) ? PP_TRAIL_HEX : PP_FAIL_HEX;
            end
            PP_OCT: begin
                if (is_oct(c)) n = PP_OCT;
                else n = is_ws(c) ? PP_TRAIL_OCT : PP_FAIL_OCT;
            end
            PP_DEC:       n = dec_step(c);
            PP_SUF: begin
                if (is_sfx(c)) n = PP_SUF;
                else n = is_ws(c) ? PP_TRAIL_DEC : PP_FAIL_DEC;
            end
            PP_TRAIL_HEX: n = is_ws(c) ? PP_TRAIL_HEX : PP_FAIL_HEX;
            PP_TRAIL_OCT: n = is_ws(c) ? PP_TRAIL_OCT : PP_FAIL_OCT;
            PP_TRAIL_DEC: n = is_ws(c) ? PP_TRAIL_DEC : PP_FAIL_DEC;
            PP_FAIL_HEX:  n = PP_FAIL_HEX;
            PP_FAIL_OCT:  n = PP_FAIL_OCT;
            default:      n = PP_FAIL_DEC;
        endcase
        return n;
    endfunction

    function automatic sci_phase_t sci_next(input sci_phase_t p, input char_t c);
        sci_phase_t n;
        n = SP_FAIL;
        case (p)
            SP_LEAD: begin
                if (is_ws(c)) n = SP_LEAD;
                else if (is_sign(c) || is_dig(c)) n = SP_DIG;
                else if (is_e(c)) n = SP_E;
                else n = SP_FAIL;
            end
            SP_DIG: begin
                if (is_dig(c)) n = SP_DIG;
                else if (is_e(c)) n = SP_E;
                else n = is_ws(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_E: begin
                if ((c == CH_PLUS) || is_dig(c)) n = SP_EXPD;
                else n = is_ws(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_EXPD: begin
                if (is_dig(c)) n = SP_EXPD;
                else n = is_ws(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_TRAIL: n = is_ws(c) ? SP_TRAIL : SP_FAIL;
            default:  n = SP_FAIL;
        endcase
        return n;
    endfunction

endpackage

FILE: design/integer_literal_classifier.sv
// integer_literal_classifier: top level, character stream in, one verdict per token out.
// Depends on icl_pkg for phase types, form codes and next-phase functions.
//
// Usage:
//   s_ channel takes one token byte per request in s_tdata, with s_tlast on the
//   final byte of the token. Only the final byte produces a request on m_:
//   m_tdata[0] is the integer verdict, m_tdata[2:1] the literal form
//   (scientific, octal, hex, decimal).
//   The verdict appears on m_ in the cycle after the final byte is taken.
//   Throughput: one byte per cycle while s_tready is high; the recognizer phases
//   update in one short combinational step from the byte and the phase registers.
//   After the final byte all recognizer state returns to its start, so the
//   next token may follow in the very next cycle.
//   The output register holds a verdict until m_tready; s_tready stays high
//   while the output register is empty or being drained in the same cycle, so
//   a stalled receiver stalls the byte stream only when a verdict is waiting.
//   Reset (aresetn low, synchronous) clears the phases, flags and m_tvalid.
module integer_literal_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_code[7:0]
    input  logic       s_tlast,   // last_char
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // is_integer[0], literal_form[2:1], zero [7:3]
);

    icl_pkg::prefix_phase_t prefix_reg, prefix_next;
    icl_pkg::sci_phase_t    sci_reg, sci_next;
    logic seen_point_reg, seen_point_next;
    logic seen_upper_e_reg, seen_upper_e_next;
    logic prev_e_reg, prev_e_next;
    logic seen_e_minus_reg, seen_e_minus_next;
    logic m_valid_reg;
    logic is_integer_reg, is_integer_next;
    icl_pkg::literal_form_t form_reg, form_next;
    logic accept;
    logic prefix_ok;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(icl_pkg::OutDataWidth - icl_pkg::FormWidth - 1){1'b0}},
                       form_reg, is_integer_reg};

    always_comb begin
        seen_point_next   = seen_point_reg || (s_tdata == icl_pkg::CH_POINT);
        seen_upper_e_next = seen_upper_e_reg || (s_tdata == icl_pkg::CH_UP_E);
        seen_e_minus_next = seen_e_minus_reg || (prev_e_reg && (s_tdata == icl_pkg::CH_MINUS));
        prev_e_next       = icl_pkg::is_e(s_tdata);
        prefix_next       = icl_pkg::prefix_next(prefix_reg, s_tdata);
        sci_next          = icl_pkg::sci_next(sci_reg, s_tdata);

        case (prefix_next)
            icl_pkg::PP_HEX, icl_pkg::PP_TRAIL_HEX, icl_pkg::PP_FAIL_HEX:
                form_next = icl_pkg::FORM_HEX;
            icl_pkg::PP_OCT, icl_pkg::PP_TRAIL_OCT, icl_pkg::PP_FAIL_OCT:
                form_next = icl_pkg::FORM_OCT;
            default:
                form_next = icl_pkg::FORM_DEC;
        endcase
        prefix_ok = (prefix_next != icl_pkg::PP_FAIL_HEX) &&
                    (prefix_next != icl_pkg::PP_FAIL_OCT) &&
                    (prefix_next != icl_pkg::PP_FAIL_DEC);
        is_integer_next = prefix_ok;
        if (seen_upper_e_next) begin
            form_next       = icl_pkg::FORM_SCI;
            is_integer_next = (sci_next != icl_pkg::SP_FAIL);
        end
        is_integer_next = is_integer_next && !seen_point_next && !seen_e_minus_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg       <= icl_pkg::PP_LEAD;
            sci_reg          <= icl_pkg::SP_LEAD;
            seen_point_reg   <= 1'b0;
            seen_upper_e_reg <= 1'b0;
            prev_e_reg       <= 1'b0;
            seen_e_minus_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (accept && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                if (s_tlast) begin
                    prefix_reg       <= icl_pkg::PP_LEAD;
                    sci_reg          <= icl_pkg::SP_LEAD;
                    seen_point_reg   <= 1'b0;
                    seen_upper_e_reg <= 1'b0;
                    prev_e_reg       <= 1'b0;
                    seen_e_minus_reg <= 1'b0;
                end else begin
                    prefix_reg       <= prefix_next;
                    sci_reg          <= sci_next;
                    seen_point_reg   <= seen_point_next;
                    seen_upper_e_reg <= seen_upper_e_next;
                    prev_e_reg       <= prev_e_next;
                    seen_e_minus_reg <= seen_e_minus_next;
                end
            end
        end
    end

    // verdict payload
    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            is_integer_reg <= is_integer_next;
            form_reg       <= form_next;
        end
    end

endmodule

FILE: tb/tb_integer_literal_classifier.sv
`timescale 1ns / 1ps
// tb_integer_literal_classifier: self-checking testbench for the integer literal classifier.
// Streams directed and random tokens with idling on both sides and checks every verdict.
// Depends on icl_pkg and integer_literal_classifier.
module tb_integer_literal_classifier;
    import icl_pkg::*;

    localparam int unsigned CycleLimit    = 200000;
    localparam int unsigned RandomChars   = 400;
    localparam int unsigned DrainCycles   = 20;
    localparam int unsigned HoldoffCycles = 300;
    localparam int unsigned HoldoffStart  = 200;
    localparam int unsigned PhaseOneEnd   = 140;
    localparam int unsigned PhaseTwoEnd   = 280;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       hold;
    } char_req_t;

    typedef struct packed {
        logic          is_integer;
        literal_form_t form;
    } verdict_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    char_req_t   char_q[$];
    char_t       tok_bytes[$];
    verdict_t    verdict_q[$];
    char_req_t   next_req;
    verdict_t    want;
    int unsigned total_chars = 0;
    int unsigned tok_n       = 0;
    int unsigned sent_n      = 0;
    int unsigned pushed_n    = 0;
    int unsigned popped_n    = 0;
    int unsigned outstanding = 0;
    int unsigned errors      = 0;
    int unsigned cycle_n     = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_done = 1'b0;

    prefix_phase_t pfx_ph      = PP_LEAD;
    sci_phase_t    sci_ph      = SP_LEAD;
    logic          saw_point   = 1'b0;
    logic          saw_upper_e = 1'b0;
    logic          prev_e      = 1'b0;
    logic          saw_e_minus = 1'b0;

    integer_literal_classifier u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // character classes
    function automatic logic ch_space(input char_t c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic ch_digit(input char_t c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic ch_octal(input char_t c);
        return c >= CH_ZERO && c <= CH_SEVEN;
    endfunction

    function automatic logic ch_hexdig(input char_t c);
        return ch_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic ch_suffix(input char_t c);
        return c == CH_LO_U || c == CH_UP_U || c == CH_LO_L || c == CH_UP_L;
    endfunction

    function automatic logic ch_e(input char_t c);
        return c == CH_LO_E || c == CH_UP_E;
    endfunction

    function automatic logic ch_sign(input char_t c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic prefix_phase_t prefix_after(input prefix_phase_t ph, input char_t c);
        prefix_phase_t digit_loop;
        if (ch_digit(c)) digit_loop = PP_DEC;
        else if (ch_suffix(c)) digit_loop = PP_SUF;
        else if (ch_space(c)) digit_loop = PP_TRAIL_DEC;
        else digit_loop = PP_FAIL_DEC;
        case (ph)
            PP_LEAD: begin
                if (ch_space(c)) return PP_LEAD;
                if (ch_sign(c)) return PP_SIGNED;
                if (c == CH_ZERO) return PP_ZERO;
                return digit_loop;
            end
            PP_SIGNED: return (c == CH_ZERO) ? PP_ZERO : digit_loop;
            PP_ZERO: begin
                if (c == CH_LO_X) return PP_HEX;
                if (ch_octal(c)) return PP_OCT;
                if (ch_digit(c)) return PP_FAIL_OCT;
                return digit_loop;
            end
            PP_HEX: begin
                if (ch_hexdig(c)) return PP_HEX;
                return ch_space(c) ? PP_TRAIL_HEX : PP_FAIL_HEX;
            end
            PP_OCT: begin
                if (ch_octal(c)) return PP_OCT;
                return ch_space(c) ? PP_TRAIL_OCT : PP_FAIL_OCT;
            end
            PP_DEC: return digit_loop;
            PP_SUF: begin
                if (ch_suffix(c)) return PP_SUF;
                return ch_space(c) ? PP_TRAIL_DEC : PP_FAIL_DEC;
            end
            PP_TRAIL_HEX: return ch_space(c) ? PP_TRAIL_HEX : PP_FAIL_HEX;
            PP_TRAIL_OCT: return ch_space(c) ? PP_TRAIL_OCT : PP_FAIL_OCT;
            PP_TRAIL_DEC: return ch_space(c) ? PP_TRAIL_DEC : PP_FAIL_DEC;
            PP_FAIL_HEX, PP_FAIL_OCT: return ph;
            default: return PP_FAIL_DEC;
        endcase
    endfunction

    function automatic sci_phase_t sci_after(input sci_phase_t ph, input char_t c);
        case (ph)
            SP_LEAD: begin
                if (ch_space(c)) return SP_LEAD;
                if (ch_sign(c) || ch_digit(c)) return SP_DIG;
                if (ch_e(c)) return SP_E;
                return SP_FAIL;
            end
            SP_DIG: begin
                if (ch_digit(c)) return SP_DIG;
                if (ch_e(c)) return SP_E;
                return ch_space(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_E: begin
                if (c == CH_PLUS || ch_digit(c)) return SP_EXPD;
                return ch_space(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_EXPD: begin
                if (ch_digit(c)) return SP_EXPD;
                return ch_space(c) ? SP_TRAIL : SP_FAIL;
            end
            SP_TRAIL: return ch_space(c) ? SP_TRAIL : SP_FAIL;
            default: return SP_FAIL;
        endcase
    endfunction

    // update token state with one character, queue the verdict on the last one
    task automatic classify_char(input char_t c, input logic last);
        verdict_t v;
        logic     ok;
        if (c == CH_POINT) saw_point = 1'b1;
        if (c == CH_UP_E) saw_upper_e = 1'b1;
        if (prev_e && c == CH_MINUS) saw_e_minus = 1'b1;
        prev_e = ch_e(c);
        pfx_ph = prefix_after(pfx_ph, c);
        sci_ph = sci_after(sci_ph, c);
        if (last) begin
            if (saw_upper_e) begin
                v.form = FORM_SCI;
                ok = (sci_ph != SP_FAIL);
            end else begin
                case (pfx_ph)
                    PP_HEX, PP_TRAIL_HEX, PP_FAIL_HEX: v.form = FORM_HEX;
                    PP_OCT, PP_TRAIL_OCT, PP_FAIL_OCT: v.form = FORM_OCT;
                    default: v.form = FORM_DEC;
                endcase
                ok = !(pfx_ph inside {PP_FAIL_HEX, PP_FAIL_OCT, PP_FAIL_DEC});
            end
            v.is_integer = ok && !saw_point && !saw_e_minus;
            verdict_q.push_back(v);
            pfx_ph = PP_LEAD;
            sci_ph = SP_LEAD;
            saw_point = 1'b0;
            saw_upper_e = 1'b0;
            prev_e = 1'b0;
            saw_e_minus = 1'b0;
        end
    endtask

    // token building
    task automatic add(input int unsigned c);
        tok_bytes.push_back(char_t'(c));
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add(s[i]);
    endtask

    task automatic flush_token(input logic hold);
        char_req_t r;
        for (int i = 0; i < tok_bytes.size(); i++) begin
            r.code = tok_bytes[i];
            r.last = (i == tok_bytes.size() - 1);
            r.hold = hold && (i == 0);
            char_q.push_back(r);
        end
        total_chars += tok_bytes.size();
        tok_n++;
        tok_bytes.delete();
    endtask

    function automatic int unsigned rand_ws();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + k;
    endfunction

    function automatic int unsigned rand_hex();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) return CH_ZERO + k;
        if (k < 16) return CH_LO_A + k - 10;
        return CH_UP_A + k - 16;
    endfunction

    function automatic int unsigned rand_suffix();
        case ($urandom_range(0, 3))
            0: return CH_LO_U;
            1: return CH_UP_U;
            2: return CH_LO_L;
            default: return CH_UP_L;
        endcase
    endfunction

    function automatic int unsigned rand_special();
        case ($urandom_range(0, 9))
            0: return CH_POINT;
            1: return CH_LO_E;
            2: return CH_UP_E;
            3: return CH_MINUS;
            4: return CH_PLUS;
            5: return CH_LO_X;
            6: return rand_ws();
            7: return CH_ZERO;
            8: return 0;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic gen_well_formed();
        if ($urandom_range(0, 3) == 0) add(rand_ws());
        if ($urandom_range(0, 2) == 0) add($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
        case ($urandom_range(0, 3))
            0: begin
                repeat ($urandom_range(1, 4)) add(CH_ZERO + $urandom_range(0, 9));
                repeat ($urandom_range(0, 2)) add(rand_suffix());
            end
            1: begin
                add(CH_ZERO);
                add(CH_LO_X);
                repeat ($urandom_range(1, 4)) add(rand_hex());
            end
            2: begin
                add(CH_ZERO);
                repeat ($urandom_range(1, 3))
                    add(($urandom_range(0, 9) == 0) ? CH_ZERO + $urandom_range(8, 9)
                                                    : CH_ZERO + $urandom_range(0, 7));
            end
            default: begin
                repeat ($urandom_range(1, 3)) add(CH_ZERO + $urandom_range(0, 9));
                add(($urandom_range(0, 3) == 0) ? CH_LO_E : CH_UP_E);
                case ($urandom_range(0, 5))
                    0, 1: add(CH_PLUS);
                    2: add(CH_MINUS);
                    default: ;
                endcase
                repeat ($urandom_range(0, 3)) add(CH_ZERO + $urandom_range(0, 9));
            end
        endcase
        if ($urandom_range(0, 3) == 0) add(rand_ws());
    endtask

    task automatic mutate_token();
        int unsigned idx;
        idx = $urandom_range(0, tok_bytes.size() - 1);
        if ($urandom_range(0, 1)) tok_bytes[idx] = char_t'(rand_special());
        else tok_bytes.insert(idx, char_t'(rand_special()));
    endtask

    function automatic logic sender_idles();
        if (sent_n < PhaseOneEnd) return $urandom_range(0, 99) < 15;
        if (sent_n < PhaseTwoEnd) return $urandom_range(0, 99) < 48;
        return 1'b0;
    endfunction

    function automatic logic receiver_idles();
        if (sent_n < PhaseOneEnd) return $urandom_range(0, 99) < 48;
        if (sent_n < PhaseTwoEnd) return $urandom_range(0, 99) < 15;
        return 1'b0;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            outstanding = pushed_n - popped_n;
            if (s_tvalid && s_tready) begin
                classify_char(s_tdata, s_tlast);
                sent_n <= sent_n + 1;
                if (s_tlast) begin
                    pushed_n <= pushed_n + 1;
                    outstanding = outstanding + 1;
                end
            end
            if (!s_tvalid || s_tready) begin
                if (char_q.size() > 0 && !(char_q[0].hold && outstanding != 0)
                        && !sender_idles()) begin
                    next_req = char_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_req.code;
                    s_tlast  <= next_req.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                popped_n <= popped_n + 1;
                if (verdict_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected request, expected none actual tdata %0h",
                             $time, m_tdata);
                end else begin
                    want = verdict_q.pop_front();
                    if (m_tdata[0] !== want.is_integer) begin
                        errors++;
                        $display("%0t: is_integer expected %0d actual %0d",
                                 $time, want.is_integer, m_tdata[0]);
                    end
                    if (m_tdata[2:1] !== want.form) begin
                        errors++;
                        $display("%0t: literal_form expected %0d actual %0d",
                                 $time, want.form, m_tdata[2:1]);
                    end
                    if (m_tdata[7:3] !== 5'd0) begin
                        errors++;
                        $display("%0t: pad bits expected 0 actual %0h", $time, m_tdata[7:3]);
                    end
                end
            end
            if (holdoff_left > 0) begin
                holdoff_left <= holdoff_left - 1;
                m_tready <= 1'b0;
            end else if (!holdoff_done && sent_n >= HoldoffStart) begin
                holdoff_left <= HoldoffCycles;
                holdoff_done <= 1'b1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !receiver_idles();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CycleLimit) begin
            $display("integer_literal_classifier regression: fail");
            $finish;
        end
    end

    initial begin
        // directed tokens
        add_text("0");     flush_token(1'b0);
        add_text("0xf");   flush_token(1'b0);
        add_text("09");    flush_token(1'b0);
        add_text("-017");  flush_token(1'b0);
        add_text("1.");    flush_token(1'b0);
        add_text("E-");    flush_token(1'b0);
        add_text("3e-");   flush_token(1'b0);
        add_text("+");     flush_token(1'b0);
        add(CH_SPACE);     flush_token(1'b0);
        add(0); add(255);  flush_token(1'b0);
        add_text("5uL");   flush_token(1'b0);
        add_text("1E5");   flush_token(1'b0);

        // random tokens, mostly well formed
        while (total_chars < RandomChars + 28) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 5)) add($urandom_range(0, 255));
            end else begin
                gen_well_formed();
                if ($urandom_range(0, 9) < 3) mutate_token();
            end
            flush_token(tok_n % 40 == 39);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk);
        while (sent_n != total_chars || pushed_n != popped_n);
        repeat (DrainCycles) @(posedge aclk);
        if (pushed_n != popped_n || verdict_q.size() != 0) begin
            errors++;
            $display("%0t: verdicts left over expected 0 actual %0d", $time, verdict_q.size());
        end
        if (errors == 0) begin
            $display("integer_literal_classifier regression: pass");
        end else begin
            $display("integer_literal_classifier regression: fail");
        end
        $finish;
    end

endmodule
